FILE: src/rfm_pkg.sv
// Shared types and constants for the RFID frame receiver and ID matcher.
package rfm_pkg;

    // Frame delimiter bytes from the tag reader.
    localparam logic [7:0] BYTE_OPEN  = 8'h02;
    localparam logic [7:0] BYTE_CLOSE = 8'h03;

    // Input word action codes.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_ARM  = 1'b1;

    // Result outcome codes.
    localparam logic [1:0] OUT_LEARNED  = 2'd0;
    localparam logic [1:0] OUT_MATCH    = 2'd1;
    localparam logic [1:0] OUT_MISMATCH = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } rfm_state_t;

endpackage

FILE: src/rfm_item_if.sv
// Valid/ready channel carrying reader bytes and learn-arm events.
interface rfm_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

FILE: src/rfm_result_if.sv
// Valid/ready channel carrying one result word per closed frame.
interface rfm_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] outcome;
    logic [3:0] frame_length;

    modport source (output valid, output outcome, output frame_length, input ready);
    modport sink   (input valid, input outcome, input frame_length, output ready);
endinterface

FILE: src/rfid_frame_receiver_id_matcher.sv
// RFID tag frame receiver with identifier learn and compare.
//
// Reader bytes and learn-arm events arrive on the item channel. A byte 0x02
// opens a frame, data bytes fill the frame buffer (up to ID_LEN of them), and
// a byte 0x03 closes the frame. On close, one shared byte lane sweeps the
// ID_LEN buffer entries, one entry per cycle, either copying them into the
// stored identifier (learn armed) or comparing them against it. Every word
// other than a frame close is taken whenever the sequencer is idle; a frame
// close holds the item channel through the sweep and the posting of the
// result, which waits if the previous result has not yet been taken. The result
// sits in an output register, so new bytes are accepted while it waits.
module rfid_frame_receiver_id_matcher
    import rfm_pkg::*;
#(
    parameter int ID_LEN = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    rfm_item_if.sink     item,
    rfm_result_if.source result
);

    localparam int CW = $clog2(ID_LEN + 1);
    localparam int IW = (ID_LEN > 1) ? $clog2(ID_LEN) : 1;

    rfm_state_t state_reg, state_next;

    logic [7:0]    frame_buffer_reg [ID_LEN];
    logic [7:0]    learned_id_reg   [ID_LEN];
    logic [CW-1:0] byte_index_reg, byte_index_next;
    logic [CW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic          in_frame_reg, in_frame_next;
    logic          learn_armed_reg, learn_armed_next;
    logic          mismatch_reg, mismatch_next;
    logic [3:0]    len_reg, len_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    outcome_reg;
    logic [3:0]    frame_length_reg;

    logic          accept;
    logic          buf_we;
    logic          id_we;
    logic          out_load;
    logic [CW+3:0] index_ext;
    logic [3:0]    len_sat;
    logic [7:0]    sweep_buf_byte;
    logic [7:0]    sweep_id_byte;

    // Handshake and shared sweep lane.
    assign item.ready     = (state_reg == ST_IDLE);
    assign accept         = item.valid && item.ready;
    assign sweep_buf_byte = frame_buffer_reg[sweep_cnt_reg[IW-1:0]];
    assign sweep_id_byte  = learned_id_reg[sweep_cnt_reg[IW-1:0]];

    // Frame length reported saturates at 15.
    always_comb
    begin
        index_ext = {4'b0000, byte_index_reg};
        if (index_ext > (CW + 4)'(15))
        begin
            len_sat = 4'hF;
        end
        else
        begin
            len_sat = index_ext[3:0];
        end
    end

    // Sequencer: next state and control.
    always_comb
    begin
        state_next       = state_reg;
        byte_index_next  = byte_index_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        in_frame_next    = in_frame_reg;
        learn_armed_next = learn_armed_reg;
        mismatch_next    = mismatch_reg;
        len_next         = len_reg;
        buf_we           = 1'b0;
        id_we            = 1'b0;
        out_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (item.action == ACT_ARM)
                    begin
                        learn_armed_next = 1'b1;
                    end
                    else if (item.rx_byte == BYTE_OPEN)
                    begin
                        in_frame_next   = 1'b1;
                        byte_index_next = '0;
                    end
                    else if (item.rx_byte == BYTE_CLOSE)
                    begin
                        if (in_frame_reg)
                        begin
                            in_frame_next   = 1'b0;
                            byte_index_next = '0;
                            len_next        = len_sat;
                            sweep_cnt_next  = '0;
                            mismatch_next   = 1'b0;
                            state_next      = ST_SWEEP;
                        end
                    end
                    else
                    begin
                        // Data bytes are kept only inside a frame and below ID_LEN.
                        if (in_frame_reg && (byte_index_reg < CW'(ID_LEN)))
                        begin
                            buf_we          = 1'b1;
                            byte_index_next = byte_index_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                if (learn_armed_reg)
                begin
                    id_we = 1'b1;
                end
                else if (sweep_buf_byte != sweep_id_byte)
                begin
                    mismatch_next = 1'b1;
                end
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == CW'(ID_LEN - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load         = 1'b1;
                    learn_armed_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            byte_index_reg  <= '0;
            sweep_cnt_reg   <= '0;
            in_frame_reg    <= 1'b0;
            learn_armed_reg <= 1'b0;
            mismatch_reg    <= 1'b0;
            len_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            byte_index_reg  <= byte_index_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            in_frame_reg    <= in_frame_next;
            learn_armed_reg <= learn_armed_next;
            mismatch_reg    <= mismatch_next;
            len_reg         <= len_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Frame buffer and stored identifier; both start out all zeros.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ID_LEN; i++)
            begin
                frame_buffer_reg[i] <= '0;
                learned_id_reg[i]   <= '0;
            end
        end
        else
        begin
            if (buf_we)
            begin
                frame_buffer_reg[byte_index_reg[IW-1:0]] <= item.rx_byte;
            end
            if (id_we)
            begin
                learned_id_reg[sweep_cnt_reg[IW-1:0]] <= sweep_buf_byte;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= '0;
            outcome_reg      <= OUT_LEARNED;
        end
        else if (out_load)
        begin
            frame_length_reg <= len_reg;
            if (learn_armed_reg)
            begin
                outcome_reg <= OUT_LEARNED;
            end
            else if (mismatch_reg)
            begin
                outcome_reg <= OUT_MISMATCH;
            end
            else
            begin
                outcome_reg <= OUT_MATCH;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.outcome      = outcome_reg;
    assign result.frame_length = frame_length_reg;

endmodule
